/* src/lbwf_pkg.sv */
// Package for the letter-bank word filter: shared constants, item codes,
// configuration and result types. No dependencies.

package lbwf_pkg;

  // Longest word length that is counted exactly; longer words saturate one above.
  localparam int MAX_WORD_LEN = 127;

  localparam int NUM_LETTERS = 26;
  localparam int HALF_LETTERS = 13;
  localparam int CNT_W = 4;
  localparam int BANK_W = HALF_LETTERS * CNT_W;
  localparam int IDX_W = $clog2(NUM_LETTERS);
  localparam int LIM_W = 7;
  localparam int WORDS_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;

  // Word length register holds 0 .. MAX_WORD_LEN + 1 and is never narrower
  // than the length limits it is compared with.
  localparam int LEN_BITS = $clog2(MAX_WORD_LEN + 2);
  localparam int LEN_W = (LEN_BITS > LIM_W) ? LEN_BITS : LIM_W;

  localparam logic [KIND_W-1:0] KIND_INNER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LAST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BANK_A_M = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_N_Z = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WORDS = 3'd4;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h7a;

  localparam logic [LIM_W-1:0] MIN_LENGTH_RST = 7'd1;
  localparam logic [LIM_W-1:0] MAX_LENGTH_RST = 7'd127;
  localparam logic [WORDS_W-1:0] MAX_WORDS_RST = 16'd16;

  typedef logic [NUM_LETTERS-1:0][CNT_W-1:0] counts_t;

  typedef struct packed {
    counts_t bank;
    logic [LIM_W-1:0] min_length;
    logic [LIM_W-1:0] max_length;
    logic [WORDS_W-1:0] max_words;
  } cfg_t;

  typedef struct packed {
    logic word_accepted;
    logic scan_stopped;
    logic [WORDS_W-1:0] accepted_total;
  } res_t;

endpackage

/* src/lbwf_cfg.sv */
// Configuration register file of the letter-bank word filter.
// Depends on lbwf_pkg for register indexes, widths and the cfg_t bundle.

module lbwf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lbwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbwf_pkg::BANK_W-1:0]    cfg_data,
  output lbwf_pkg::cfg_t                 cfg
);

  logic [lbwf_pkg::BANK_W-1:0]  bank_lo;
  logic [lbwf_pkg::BANK_W-1:0]  bank_hi;
  logic [lbwf_pkg::LIM_W-1:0]   min_length;
  logic [lbwf_pkg::LIM_W-1:0]   max_length;
  logic [lbwf_pkg::WORDS_W-1:0] max_words;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_lo    <= '0;
      bank_hi    <= '0;
      min_length <= lbwf_pkg::MIN_LENGTH_RST;
      max_length <= lbwf_pkg::MAX_LENGTH_RST;
      max_words  <= lbwf_pkg::MAX_WORDS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lbwf_pkg::REG_BANK_A_M:   bank_lo    <= cfg_data;
        lbwf_pkg::REG_BANK_N_Z:   bank_hi    <= cfg_data;
        lbwf_pkg::REG_MIN_LENGTH: min_length <= cfg_data[lbwf_pkg::LIM_W-1:0];
        lbwf_pkg::REG_MAX_LENGTH: max_length <= cfg_data[lbwf_pkg::LIM_W-1:0];
        lbwf_pkg::REG_MAX_WORDS:  max_words  <= cfg_data[lbwf_pkg::WORDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Letter a sits in the low nibble of the first bank register.
  assign cfg.bank       = {bank_hi, bank_lo};
  assign cfg.min_length = min_length;
  assign cfg.max_length = max_length;
  assign cfg.max_words  = max_words;

endmodule

/* src/lbwf_core.sv */
// Word state and decision logic of the letter-bank word filter: per-letter
// remaining counts, word length, failure flag, accepted count and stop flag.
// Depends on lbwf_pkg.

module lbwf_core (
  input  logic                        clk,
  input  logic                        rst,
  input  lbwf_pkg::cfg_t              cfg,
  input  logic                        step,
  input  logic [lbwf_pkg::KIND_W-1:0] kind,
  input  logic [lbwf_pkg::CHAR_W-1:0] letter,
  output logic                        res_valid,
  output lbwf_pkg::res_t              res
);

  lbwf_pkg::counts_t              remaining;
  lbwf_pkg::counts_t              remaining_next;
  logic [lbwf_pkg::LEN_W-1:0]     word_length;
  logic [lbwf_pkg::LEN_W-1:0]     word_length_next;
  logic                           word_failed;
  logic                           word_failed_next;
  logic [lbwf_pkg::WORDS_W-1:0]   accepted_count;
  logic [lbwf_pkg::WORDS_W-1:0]   accepted_count_next;
  logic                           stopped_flag;
  logic                           stopped_flag_next;

  lbwf_pkg::counts_t              counts_eff;
  logic                           is_lower;
  logic [lbwf_pkg::CHAR_W-1:0]    letter_off;
  logic [lbwf_pkg::IDX_W-1:0]     idx;
  logic [lbwf_pkg::LEN_W-1:0]     len_take;
  logic                           fail_take;
  logic                           qualifies;
  logic                           under_limit;
  logic                           take;

  always_comb begin
    // A new word starts from a fresh copy of the bank.
    counts_eff = (word_length == '0) ? cfg.bank : remaining;
    is_lower   = (letter >= lbwf_pkg::CHAR_A) && (letter <= lbwf_pkg::CHAR_Z);
    letter_off = letter - lbwf_pkg::CHAR_A;
    idx        = letter_off[lbwf_pkg::IDX_W-1:0];
    len_take   = (word_length <= lbwf_pkg::LEN_W'(lbwf_pkg::MAX_WORD_LEN)) ?
                 word_length + 1'b1 : word_length;

    remaining_next = counts_eff;
    fail_take      = word_failed;
    if (!word_failed) begin
      if (!is_lower) begin
        fail_take = 1'b1;
      end else if (counts_eff[idx] == '0) begin
        fail_take = 1'b1;
      end else begin
        remaining_next[idx] = counts_eff[idx] - 1'b1;
      end
    end

    qualifies = !fail_take &&
                (len_take <= lbwf_pkg::LEN_W'(lbwf_pkg::MAX_WORD_LEN)) &&
                (len_take >= lbwf_pkg::LEN_W'(cfg.min_length)) &&
                (len_take <= lbwf_pkg::LEN_W'(cfg.max_length));
    under_limit = (accepted_count == '0) || (accepted_count < cfg.max_words);

    // Only word characters of a running scan step the word state; a restart clears it.
    take = step && (kind == lbwf_pkg::KIND_INNER || kind == lbwf_pkg::KIND_LAST) &&
           !stopped_flag;

    word_length_next    = word_length;
    word_failed_next    = word_failed;
    accepted_count_next = accepted_count;
    stopped_flag_next   = stopped_flag;
    res_valid           = 1'b0;
    res                 = '0;

    if (step) begin
      if (kind == lbwf_pkg::KIND_RESTART) begin
        word_length_next    = '0;
        word_failed_next    = 1'b0;
        accepted_count_next = '0;
        stopped_flag_next   = 1'b0;
      end else if (take) begin
        word_length_next = len_take;
        word_failed_next = fail_take;
        if (kind == lbwf_pkg::KIND_LAST) begin
          word_length_next = '0;
          word_failed_next = 1'b0;
          res_valid        = 1'b1;
          if (qualifies) begin
            if (under_limit) begin
              res.word_accepted = 1'b1;
              if (accepted_count != '1) begin
                accepted_count_next = accepted_count + 1'b1;
              end
            end else begin
              res.scan_stopped  = 1'b1;
              stopped_flag_next = 1'b1;
            end
          end
          res.accepted_total = accepted_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length    <= '0;
      word_failed    <= 1'b0;
      accepted_count <= '0;
      stopped_flag   <= 1'b0;
    end else begin
      word_length    <= word_length_next;
      word_failed    <= word_failed_next;
      accepted_count <= accepted_count_next;
      stopped_flag   <= stopped_flag_next;
    end
  end

  // Counts are reloaded at every word start, so they need no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      remaining <= remaining_next;
    end
  end

  a_accept_xor_stop: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.word_accepted && res.scan_stopped))
    else $error("word both accepted and refused");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    word_length <= lbwf_pkg::LEN_W'(lbwf_pkg::MAX_WORD_LEN + 1))
    else $error("word length beyond saturation point");

  a_stopped_frozen: assert property (@(posedge clk) disable iff (rst)
    (stopped_flag && !(step && kind == lbwf_pkg::KIND_RESTART)) |=>
      ($stable(accepted_count) && stopped_flag))
    else $error("state moved while scan stopped");

  a_stop_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.scan_stopped) |=> stopped_flag)
    else $error("refusal did not stop the scan");

  a_accept_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.word_accepted) |-> (res.accepted_total != '0))
    else $error("accepted word left a zero total");

endmodule

/* src/letter_bank_word_filter.sv */
// Letter-bank word filter: scans a dictionary one character per transaction
// and, at each word's last character, reports whether the word is spelled from
// a configured bank of letters. Throughput is one character per clock while
// no result is stalled: the character goes from an input register through the
// count check and decrement in lbwf_core into a result register that drives
// result_valid. A stalled result register holds up the input register only;
// one further character is still taken. Restart, inner and ignored characters
// give no result transaction. Configuration is written through lbwf_cfg and
// must only change while the filter is idle.
// Depends on lbwf_pkg, lbwf_cfg and lbwf_core.

module letter_bank_word_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lbwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbwf_pkg::BANK_W-1:0]    cfg_data,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [lbwf_pkg::KIND_W-1:0]    kind,
  input  logic [lbwf_pkg::CHAR_W-1:0]    letter,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           word_accepted,
  output logic                           scan_stopped,
  output logic [lbwf_pkg::WORDS_W-1:0]   accepted_total
);

  lbwf_pkg::cfg_t              cfg;
  logic                        held;
  logic [lbwf_pkg::KIND_W-1:0] kind_q;
  logic [lbwf_pkg::CHAR_W-1:0] letter_q;
  logic                        step;
  logic                        res_valid;
  lbwf_pkg::res_t              res;
  lbwf_pkg::res_t              res_q;

  lbwf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held character moves on whenever the result register can take a result.
  assign step       = held && (!result_valid || result_ready);
  assign item_ready = !held || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_ready) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      kind_q   <= kind;
      letter_q <= letter;
    end
  end

  lbwf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .kind      (kind_q),
    .letter    (letter_q),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && res_valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      res_q <= res;
    end
  end

  assign word_accepted  = res_q.word_accepted;
  assign scan_stopped   = res_q.scan_stopped;
  assign accepted_total = res_q.accepted_total;

endmodule

/* dv/tb_letter_bank_word_filter.sv */
// Self-checking testbench for letter_bank_word_filter. It streams dictionary
// characters with random idling and back-pressure, predicts every word verdict
// and compares each result field by field. Depends on lbwf_pkg and the filter RTL.

module tb_letter_bank_word_filter;
  import lbwf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int PHASE_CHARS = 110;
  localparam int WORD_GOOD = 0;
  localparam int WORD_BAD_LETTER = 1;
  localparam int WORD_BAD_BYTE = 2;
  localparam int WORD_NOISE = 3;

  class word_filter_scoreboard;
    logic [BANK_W-1:0] bank_a_m;
    logic [BANK_W-1:0] bank_n_z;
    logic [LIM_W-1:0] min_len;
    logic [LIM_W-1:0] max_len;
    logic [WORDS_W-1:0] word_limit;
    counts_t letters_left;
    logic [LEN_W-1:0] chars_in_word;
    logic word_spoiled;
    logic [WORDS_W-1:0] words_taken;
    logic scan_halted;
    res_t pending_verdicts[$];
    int mismatches;
    int live_chars;

    function new();
      bank_a_m = '0;
      bank_n_z = '0;
      min_len = MIN_LENGTH_RST;
      max_len = MAX_LENGTH_RST;
      word_limit = MAX_WORDS_RST;
      letters_left = '0;
      chars_in_word = '0;
      word_spoiled = 1'b0;
      words_taken = '0;
      scan_halted = 1'b0;
      mismatches = 0;
      live_chars = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BANK_W-1:0] data);
      case (idx)
        REG_BANK_A_M: bank_a_m = data;
        REG_BANK_N_Z: bank_n_z = data;
        REG_MIN_LENGTH: min_len = data[LIM_W-1:0];
        REG_MAX_LENGTH: max_len = data[LIM_W-1:0];
        REG_MAX_WORDS: word_limit = data[WORDS_W-1:0];
        default: ;
      endcase
    endfunction

    // Called for every accepted input transaction; queues a verdict when the
    // character closes a word and the scan is still running.
    function void note_item(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] slot;
      logic qualifies;
      res_t verdict;
      if (k == KIND_RESTART) begin
        words_taken = '0;
        scan_halted = 1'b0;
        chars_in_word = '0;
        word_spoiled = 1'b0;
        live_chars++;
        return;
      end
      if (k == KIND_UNUSED || scan_halted) return;
      live_chars++;
      // The bank is copied in only at a word's first character.
      if (chars_in_word == 0) letters_left = {bank_n_z, bank_a_m};
      if (chars_in_word <= MAX_WORD_LEN) chars_in_word++;
      if (!word_spoiled) begin
        if (ch < CHAR_A || ch > CHAR_Z) begin
          word_spoiled = 1'b1;
        end else begin
          slot = ch - CHAR_A;
          if (letters_left[slot] == 0) word_spoiled = 1'b1;
          else letters_left[slot] = letters_left[slot] - 1'b1;
        end
      end
      if (k == KIND_INNER) return;

      qualifies = !word_spoiled && chars_in_word <= MAX_WORD_LEN &&
                  chars_in_word >= min_len && chars_in_word <= max_len;
      verdict.word_accepted = 1'b0;
      verdict.scan_stopped = 1'b0;
      if (qualifies) begin
        if (words_taken == 0 || words_taken < word_limit) begin
          verdict.word_accepted = 1'b1;
          if (words_taken != '1) words_taken++;
        end else begin
          verdict.scan_stopped = 1'b1;
          scan_halted = 1'b1;
        end
      end
      verdict.accepted_total = words_taken;
      chars_in_word = '0;
      word_spoiled = 1'b0;
      pending_verdicts.push_back(verdict);
    endfunction

    function void check_verdict(logic wa, logic ss, logic [WORDS_W-1:0] total);
      res_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result transaction with no verdict pending: word_accepted %0d scan_stopped %0d accepted_total %0d",
               wa, ss, total);
        mismatches++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (want.word_accepted !== wa) begin
        $error("word_accepted: expected %0d, actual %0d", want.word_accepted, wa);
        mismatches++;
      end
      if (want.scan_stopped !== ss) begin
        $error("scan_stopped: expected %0d, actual %0d", want.scan_stopped, ss);
        mismatches++;
      end
      if (want.accepted_total !== total) begin
        $error("accepted_total: expected %0d, actual %0d", want.accepted_total, total);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BANK_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [KIND_W-1:0] kind = KIND_INNER;
  logic [CHAR_W-1:0] letter = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic word_accepted;
  logic scan_stopped;
  logic [WORDS_W-1:0] accepted_total;

  word_filter_scoreboard sb = new();

  counts_t bank_now = '0;
  bit quiet = 1'b0;
  bit tx_steady = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int rx_stall = 0;

  letter_bank_word_filter u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .kind           (kind),
    .letter         (letter),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .word_accepted  (word_accepted),
    .scan_stopped   (scan_stopped),
    .accepted_total (accepted_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample every handshake at the edge where it completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (item_valid && item_ready) sb.note_item(kind, letter);
      if (result_valid && result_ready) sb.check_verdict(word_accepted, scan_stopped, accepted_total);
    end
  end

  // Result side: random stall bursts, plus a long hold whenever one is requested.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      rx_stall = LONG_HOLD_CYCLES;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      result_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(0, 9);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  function automatic logic [CHAR_W-1:0] nth_letter(int n);
    return CHAR_A + CHAR_W'(n);
  endfunction

  function automatic counts_t random_bank();
    counts_t b;
    for (int i = 0; i < NUM_LETTERS; i++)
      b[i] = ($urandom_range(0, 3) == 0) ? 4'd0 : CNT_W'($urandom_range(1, 15));
    return b;
  endfunction

  task automatic maybe_pause_sender();
    if (!quiet && !tx_steady && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch);
    maybe_pause_sender();
    item_valid <= 1'b1;
    kind <= k;
    letter <= ch;
    do @(posedge clk); while (item_ready !== 1'b1);
  endtask

  // Leaves cfg_valid high so back-to-back writes follow without a gap in cfg_valid.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BANK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_config(input counts_t bank, input logic [LIM_W-1:0] lo,
                            input logic [LIM_W-1:0] hi, input logic [WORDS_W-1:0] words);
    logic [BANK_W-1:0] junk;
    bank_now = bank;
    write_reg(REG_BANK_A_M, bank[HALF_LETTERS-1:0]);
    write_reg(REG_BANK_N_Z, bank[NUM_LETTERS-1:HALF_LETTERS]);
    // Bits above a narrow register carry random junk that must be dropped.
    junk = BANK_W'({$urandom(), $urandom()});
    write_reg(REG_MIN_LENGTH, {junk[BANK_W-1:LIM_W], lo});
    junk = BANK_W'({$urandom(), $urandom()});
    write_reg(REG_MAX_LENGTH, {junk[BANK_W-1:LIM_W], hi});
    junk = BANK_W'({$urandom(), $urandom()});
    write_reg(REG_MAX_WORDS, {junk[BANK_W-1:WORDS_W], words});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_verdicts();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // Characters that give no result may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Good words draw letters from what the bank still holds; a bad-letter word
  // takes one letter the bank has run out of.
  task automatic send_word(input int len, input int mode);
    counts_t avail;
    int spoil_at;
    int start;
    int pick;
    logic [CHAR_W-1:0] ch;
    avail = bank_now;
    spoil_at = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      start = $urandom_range(0, NUM_LETTERS - 1);
      pick = -1;
      if (mode == WORD_NOISE) begin
        ch = CHAR_W'($urandom_range(0, 255));
      end else if (mode == WORD_BAD_BYTE && i == spoil_at) begin
        ch = CHAR_W'($urandom_range(0, 255));
        if (ch >= CHAR_A && ch <= CHAR_Z) ch = ch ^ 8'h80;
      end else begin
        for (int j = 0; j < NUM_LETTERS && pick < 0; j++)
          if ((avail[(start + j) % NUM_LETTERS] == 0) == (mode == WORD_BAD_LETTER && i == spoil_at))
            pick = (start + j) % NUM_LETTERS;
        if (pick < 0) pick = start;
        if (avail[pick] != 0) avail[pick] = avail[pick] - 1'b1;
        ch = nth_letter(pick);
      end
      send_char((i == len - 1) ? KIND_LAST : KIND_INNER, ch);
    end
  endtask

  task automatic random_step(input int longest);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 62) send_word($urandom_range(1, longest), WORD_GOOD);
    else if (roll < 70) send_word($urandom_range(1, longest), WORD_BAD_LETTER);
    else if (roll < 76) send_word($urandom_range(1, longest), WORD_BAD_BYTE);
    else if (roll < 84) send_char(KIND_RESTART, CHAR_W'($urandom_range(0, 255)));
    else if (roll < 88) send_char(KIND_UNUSED, CHAR_W'($urandom_range(0, 255)));
    else send_word($urandom_range(1, 4), WORD_NOISE);
  endtask

  initial begin
    counts_t bank;
    int phase_end;
    logic [LIM_W-1:0] lo;
    logic [LIM_W-1:0] hi;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the bank is empty, so even one letter is refused.
    send_char(KIND_LAST, CHAR_A);
    wait_for_verdicts();

    write_reg(REG_UNUSED, BANK_W'({$urandom(), $urandom()}));
    bank = '0;
    bank[0] = 4'd2;
    bank[1] = 4'd1;
    bank[12] = 4'd1;
    bank[13] = 4'd1;
    bank[25] = 4'hF;
    set_config(bank, 7'd1, 7'd5, 16'd3);

    send_char(KIND_LAST, CHAR_A);
    send_char(KIND_INNER, CHAR_A);
    send_char(KIND_LAST, nth_letter(1));
    // Third 'a' is more than the bank holds.
    send_char(KIND_INNER, CHAR_A);
    send_char(KIND_INNER, CHAR_A);
    send_char(KIND_LAST, CHAR_A);
    send_char(KIND_LAST, 8'h60);
    send_char(KIND_INNER, 8'h7b);
    send_char(KIND_LAST, CHAR_Z);
    send_char(KIND_UNUSED, 8'hFF);
    send_char(KIND_INNER, CHAR_Z);
    send_char(KIND_LAST, CHAR_Z);
    // Limit reached: this word stops the scan, the next one is ignored.
    send_char(KIND_LAST, nth_letter(12));
    send_char(KIND_LAST, nth_letter(13));
    send_char(KIND_RESTART, 8'h00);
    send_char(KIND_INNER, CHAR_Z);
    send_char(KIND_LAST, nth_letter(13));
    // Spelled from the bank but one character too long.
    send_char(KIND_INNER, CHAR_A);
    send_char(KIND_INNER, nth_letter(1));
    repeat (3) send_char(KIND_INNER, CHAR_Z);
    send_char(KIND_LAST, CHAR_Z);
    wait_for_verdicts();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_config(random_bank(), 7'd1, 7'd127, 16'd8);
        1: set_config({NUM_LETTERS{4'hF}}, 7'd127, 7'd127, 16'd4);
        2: set_config(random_bank(), 7'd1, 7'd1, 16'd0);
        3: set_config(random_bank(), 7'd1, 7'd127, 16'hFFFF);
        4: set_config('0, 7'd2, 7'd6, 16'd5);
        default: begin
          lo = LIM_W'($urandom_range(1, 4));
          hi = ($urandom_range(0, 3) == 0) ? 7'd127 : LIM_W'($urandom_range(3, 9));
          set_config(random_bank(), lo, hi, WORDS_W'($urandom_range(1, 20)));
        end
      endcase
      if (p == 9) quiet = 1'b1;
      if (p == 1 || p == 3 || $urandom_range(0, 1) == 1)
        send_char(KIND_RESTART, CHAR_W'($urandom_range(0, 255)));

      if (p == 1) begin
        // Longest counted length, a word past saturation, and one just short.
        send_word(127, WORD_GOOD);
        send_word(129, WORD_GOOD);
        send_word(126, WORD_GOOD);
      end
      if (p == 3) begin
        // Hold results off while single-letter words keep coming, so the
        // filter fills up and stalls its input.
        hold_requests++;
        tx_steady = 1'b1;
        repeat (30) send_word(1, WORD_GOOD);
        tx_steady = 1'b0;
      end

      phase_end = sb.live_chars + ((p == 1) ? 30 : PHASE_CHARS);
      while (sb.live_chars < phase_end) random_step((p == 2) ? 3 : 10);

      // Sometimes leave a word open across the next register writes; the new
      // bank must not apply until the following word starts.
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 3)) send_char(KIND_INNER, nth_letter($urandom_range(0, 25)));
      wait_for_verdicts();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS letter_bank_word_filter");
    end else begin
      $display("FAIL letter_bank_word_filter");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAIL letter_bank_word_filter");
    $finish;
  end

endmodule
